// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rcd_pkg.sv =====
// Shared constants and types of the repetition code decoder.
package rcd_pkg;

  localparam int unsigned MAX_BLOCK     = 1024;
  localparam int unsigned MAX_REPS      = 16;
  localparam int unsigned LLR_WIDTH     = 16;
  localparam int unsigned ACC_WIDTH     = 20;
  localparam int unsigned POS_WIDTH     = 10;
  localparam int unsigned REP_WIDTH     = 4;
  localparam int unsigned BLK_WIDTH     = 11;
  localparam int unsigned REPS_WIDTH    = 5;
  localparam int unsigned CFG_WIDTH     = 11;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_SOFT_MODE    = 2'd0,
    CFG_BLOCK_LENGTH = 2'd1,
    CFG_REPETITIONS  = 2'd2
  } cfg_idx_e;

  // Transaction in flight between accumulator read and write-back
  typedef struct packed {
    logic                 valid;
    logic [POS_WIDTH-1:0] pos;
    logic [ACC_WIDTH-1:0] contrib;
    logic                 first;
    logic                 last_rep;
    logic                 last_bit;
  } rmw_stage_t;

endpackage

// ===== design/rcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/repetition_code_decoder.sv =====
// Repetition code decoder: one LLR per cycle, hard or soft majority per bit.
// Takes one LLR transaction per clock cycle sustained, provided results are taken as
// they appear. Each LLR costs one read-modify-write of its bit's 20-bit accumulator in a
// 1024-entry RAM with registered read data; on a bit's last repetition its result goes
// to the output register. Back-to-back LLRs of the same bit (block length one)
// are handled by forwarding the value being written back. No clearing pass is needed:
// the first repetition of every codeword overwrites each accumulator. A configuration
// write restarts the codeword at bit 0, repetition 0.
module repetition_code_decoder
  import rcd_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [LLR_WIDTH-1:0] llr_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [POS_WIDTH-1:0]        bit_index_o,
  output logic                        decided_bit_o,
  output logic                        last_bit_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]        cfg_data_i
);

  // Configuration registers
  logic                  soft_mode_q, soft_mode_d;
  logic [BLK_WIDTH-1:0]  block_length_q, block_length_d;
  logic [REPS_WIDTH-1:0] repetitions_q, repetitions_d;
  logic                  restart;

  // Codeword position
  logic [POS_WIDTH-1:0]  pos_q, pos_d;
  logic [REP_WIDTH-1:0]  rep_q, rep_d;

  // Pipeline
  rmw_stage_t            s1_q, s1_d;
  logic                  fwd_hit_q, fwd_hit_d;
  logic [ACC_WIDTH-1:0]  fwd_data_q;
  logic                  s1_adv;
  logic                  in_accept;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [POS_WIDTH-1:0]  bit_index_q;
  logic                  decided_bit_q;
  logic                  last_bit_q;
  logic                  out_load;

  // Effective configuration and accumulator path
  logic [BLK_WIDTH-1:0]  k_m1;
  logic [REPS_WIDTH-1:0] r_m1;
  logic                  at_last_pos;
  logic                  at_last_rep;
  logic [ACC_WIDTH-1:0]  contrib;
  logic [ACC_WIDTH-1:0]  acc_old;
  logic [ACC_WIDTH-1:0]  acc_new;
  logic [ACC_WIDTH-1:0]  ram_rdata;
  logic                  ram_we;

  // Clamp the configured sizes into range, minus one for end tests
  always_comb begin
    if (block_length_q == '0) begin
      k_m1 = '0;
    end else if (block_length_q > BLK_WIDTH'(MAX_BLOCK)) begin
      k_m1 = BLK_WIDTH'(MAX_BLOCK - 1);
    end else begin
      k_m1 = block_length_q - BLK_WIDTH'(1);
    end
    if (repetitions_q == '0) begin
      r_m1 = '0;
    end else if (repetitions_q > REPS_WIDTH'(MAX_REPS)) begin
      r_m1 = REPS_WIDTH'(MAX_REPS - 1);
    end else begin
      r_m1 = repetitions_q - REPS_WIDTH'(1);
    end
  end

  assign at_last_pos = ({1'b0, pos_q} == k_m1);
  assign at_last_rep = ({1'b0, rep_q} == r_m1);

  // Per-LLR contribution: sign vote or the value itself
  always_comb begin
    if (soft_mode_q) begin
      contrib = ACC_WIDTH'(signed'(llr_i));
    end else if (llr_i[LLR_WIDTH-1]) begin
      contrib = '1;
    end else begin
      contrib = ACC_WIDTH'(1);
    end
  end

  // Handshake: stage 1 drains whenever the output register can take a result
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_q.valid || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;
  assign ram_we     = s1_q.valid && s1_adv;
  assign out_load   = ram_we && s1_q.last_rep;

  // Accumulate, with forwarding from the write-back that overlapped the read
  assign acc_old = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign acc_new = s1_q.first ? s1_q.contrib : acc_old + s1_q.contrib;

  // Configuration writes
  always_comb begin
    soft_mode_d    = soft_mode_q;
    block_length_d = block_length_q;
    repetitions_d  = repetitions_q;
    restart        = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SOFT_MODE: begin
          soft_mode_d = cfg_data_i[0];
          restart     = 1'b1;
        end
        CFG_BLOCK_LENGTH: begin
          block_length_d = cfg_data_i[BLK_WIDTH-1:0];
          restart        = 1'b1;
        end
        CFG_REPETITIONS: begin
          repetitions_d = cfg_data_i[REPS_WIDTH-1:0];
          restart       = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // Codeword position counters
  always_comb begin
    pos_d = pos_q;
    rep_d = rep_q;
    if (restart) begin
      pos_d = '0;
      rep_d = '0;
    end else if (in_accept) begin
      if (at_last_pos) begin
        pos_d = '0;
        rep_d = at_last_rep ? '0 : rep_q + REP_WIDTH'(1);
      end else begin
        pos_d = pos_q + POS_WIDTH'(1);
      end
    end
  end

  // Stage 1 load and forward detection
  always_comb begin
    s1_d      = s1_q;
    fwd_hit_d = fwd_hit_q;
    if (in_accept) begin
      s1_d.valid    = 1'b1;
      s1_d.pos      = pos_q;
      s1_d.contrib  = contrib;
      s1_d.first    = (rep_q == '0);
      s1_d.last_rep = at_last_rep;
      s1_d.last_bit = at_last_pos;
      fwd_hit_d     = ram_we && (s1_q.pos == pos_q);
    end else if (s1_adv) begin
      s1_d.valid = 1'b0;
    end
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_mode_q    <= 1'b0;
      block_length_q <= BLK_WIDTH'(1);
      repetitions_q  <= REPS_WIDTH'(3);
      pos_q          <= '0;
      rep_q          <= '0;
      s1_q           <= '0;
      fwd_hit_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      soft_mode_q    <= soft_mode_d;
      block_length_q <= block_length_d;
      repetitions_q  <= repetitions_d;
      pos_q          <= pos_d;
      rep_q          <= rep_d;
      s1_q           <= s1_d;
      fwd_hit_q      <= fwd_hit_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_data_q <= acc_new;
    end
    if (out_load) begin
      bit_index_q   <= s1_q.pos;
      decided_bit_q <= acc_new[ACC_WIDTH-1] || (acc_new == '0);
      last_bit_q    <= s1_q.last_bit;
    end
  end

  // Accumulator store
  rcd_ram #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (MAX_BLOCK)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.pos),
    .wdata_i (acc_new),
    .re_i    (in_accept),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign bit_index_o   = bit_index_q;
  assign decided_bit_o = decided_bit_q;
  assign last_bit_o    = last_bit_q;

endmodule

// ===== design/rcd_checker.sv =====
// Port-level checker for the repetition code decoder, bound to the top level.
`include "assert_macros.svh"

module rcd_checker
  import rcd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [POS_WIDTH-1:0] bit_index_o,
  input logic                 last_bit_o
);

  // A pending result is not withdrawn
  `RCD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // The highest bit position always closes the codeword
  `RCD_ASSERT(a_top_index_last, !(out_valid_o && !last_bit_o && (bit_index_o == '1)),
              "top bit index without last_bit")

  // A new result traces back through stage 1 to an accepted transaction
  `RCD_ASSERT(a_out_cause, !$rose(out_valid_o) || $past(in_valid_i && in_ready_o, 2),
              "result without input")

  // Input is never held off while the output side is ready
  `RCD_ASSERT(a_no_stall, !out_ready_i || in_ready_o, "input stalled with output ready")

endmodule

bind repetition_code_decoder rcd_checker u_rcd_checker (.*);
